/* sv/mcs_pkg.sv */
`default_nettype none
package mcs_pkg;
  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeClear = 2'd1;
  localparam logic [1:0] ModeRun   = 2'd2;

  localparam logic [6:0] NodeCountReset = 7'd64;
  localparam logic [1:0] AddrNodeCount  = 2'd0;

  // color table marker for a node not yet colored
  localparam logic [6:0] Uncolored = 7'd127;

  // controller to datapath commands
  typedef struct packed {
    logic add;       // set one adjacency bit
    logic clr_row;   // clear adjacency row at sweep index
    logic init;      // init run state at sweep index
    logic scan;      // search scan: read weight and flag of node j
    logic pick;      // commit pick of round i
    logic upd;       // weight update: read weight of node j
    logic col_ord;   // start coloring node i: read its search order entry
    logic col_rd;    // latch row of node being colored
    logic col_chk;   // coloring check: read color of neighbor j
    logic col_emit;  // write color of node i, emit result
    logic rst_j;     // reset inner counter
    logic inc_j;     // step inner counter
    logic rst_i;     // reset outer counter
    logic inc_i;     // step outer counter
  } mcs_cmd_t;

  typedef struct packed {
    logic j_last;    // inner counter at last index
    logic i_last;    // outer counter at last index
    logic empty;     // active node count is zero
  } mcs_sts_t;
endpackage
`default_nettype wire

/* sv/mcs_datapath.sv */
`default_nettype none
module mcs_datapath #(
  parameter int MaxNodes = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mcs_pkg::mcs_cmd_t cmd_i,
  output mcs_pkg::mcs_sts_t      sts_o,
  input  wire logic [6:0]        node_count_i,
  input  wire logic [5:0]        from_node_i,
  input  wire logic [5:0]        to_node_i,
  output logic                   res_valid_o,
  output logic [5:0]             node_index_o,
  output logic [5:0]             node_color_o,
  output logic                   last_o
);
  localparam int IW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int Lim = (MaxNodes < 64) ? MaxNodes : 64;
  localparam int CW = $clog2(Lim + 1);

  // storage
  logic [63:0] adj_mem [MaxNodes];
  logic [6:0]  wgt_mem [MaxNodes];
  logic        rem_mem [MaxNodes];
  logic [5:0]  ord_mem [MaxNodes];
  logic [6:0]  col_mem [MaxNodes];

  logic [IW-1:0] i_q, j_q;
  logic [CW-1:0] lim;
  logic [63:0]   act;
  logic [63:0]   row_q, used_q;
  logic [7:0]    best_q;
  logic [5:0]    bidx_q;
  logic [5:0]    v_q;

  // registered table reads, one register behind the counter
  logic          scan_q, upd_q, chk_q;
  logic [IW-1:0] rd_idx_q;
  logic [6:0]    rd_wgt_q;
  logic          rd_rem_q;
  logic [6:0]    rd_col_q;
  logic [5:0]    rd_j6;

  // active limit, saturated
  always_comb begin
    if (node_count_i > 7'(Lim)) lim = CW'(Lim);
    else lim = node_count_i[CW-1:0];
  end

  assign sts_o.j_last = ((32'(j_q) + 32'd1) == 32'(lim));
  assign sts_o.i_last = ((32'(i_q) + 32'd1) == 32'(lim));
  assign sts_o.empty  = (lim == '0);

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      if (cmd_i.rst_j) j_q <= '0;
      else if (cmd_i.inc_j) j_q <= j_q + IW'(1);
      if (cmd_i.rst_i) i_q <= '0;
      else if (cmd_i.inc_i) i_q <= i_q + IW'(1);
    end
  end

  assign rd_j6 = 6'(rd_idx_q);
  assign act = (32'(lim) >= 32'd64) ? '1 : ((64'd1 << lim) - 64'd1);

  // adjacency store
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && (32'(from_node_i) < MaxNodes))
      adj_mem[IW'(from_node_i)][to_node_i] <= 1'b1;
    else if (cmd_i.clr_row)
      adj_mem[i_q] <= '0;
  end

  // removed flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) rem_mem[i_q] <= 1'b0;
    else if (cmd_i.pick) rem_mem[IW'(bidx_q)] <= 1'b1;
  end

  // weights: write back the registered read plus one for neighbors
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) wgt_mem[i_q] <= '0;
    else if (upd_q && row_q[rd_j6]) wgt_mem[rd_idx_q] <= rd_wgt_q + 7'd1;
  end

  // colors
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) col_mem[i_q] <= mcs_pkg::Uncolored;
    else if (cmd_i.col_emit) col_mem[IW'(v_q)] <= {1'b0, node_color_o};
  end

  // search order
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) ord_mem[i_q] <= bidx_q;
  end

  // table reads at the inner counter, node being colored
  always_ff @(posedge clk_i) begin
    rd_idx_q <= j_q;
    rd_wgt_q <= wgt_mem[j_q];
    rd_rem_q <= rem_mem[j_q];
    rd_col_q <= col_mem[j_q];
    if (cmd_i.col_ord) v_q <= ord_mem[i_q];
  end

  // read-valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 1'b0;
      upd_q  <= 1'b0;
      chk_q  <= 1'b0;
    end else begin
      scan_q <= cmd_i.scan;
      upd_q  <= cmd_i.upd;
      chk_q  <= cmd_i.col_chk;
    end
  end

  // best tracking, row latch and used set
  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.pick) begin
      best_q <= 8'hFF;
    end else if (scan_q && !rd_rem_q &&
                 ((best_q == 8'hFF) || ({1'b0, rd_wgt_q} > best_q))) begin
      best_q <= {1'b0, rd_wgt_q};
      bidx_q <= rd_j6;
    end
    if (cmd_i.pick) row_q <= adj_mem[IW'(bidx_q)] & act;
    else if (cmd_i.col_rd) row_q <= adj_mem[IW'(v_q)] & act;
    if (cmd_i.col_rd) used_q <= '0;
    else if (chk_q && row_q[rd_j6] && (rd_col_q != mcs_pkg::Uncolored))
      used_q[rd_col_q[5:0]] <= 1'b1;
  end

  // smallest free color
  always_comb begin
    node_color_o = 6'd63;
    for (int k = 62; k >= 0; k--)
      if (!used_q[k]) node_color_o = 6'(k);
  end

  assign res_valid_o  = cmd_i.col_emit;
  assign node_index_o = v_q;
  assign last_o       = sts_o.i_last;
endmodule
`default_nettype wire

/* sv/mcs_ctrl.sv */
`default_nettype none
module mcs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic              sweep_i,
  output logic                   busy_o,
  output mcs_pkg::mcs_cmd_t      cmd_o,
  input  wire mcs_pkg::mcs_sts_t sts_i
);
  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SClr     = 4'd1;
  localparam logic [3:0] SInit    = 4'd2;
  localparam logic [3:0] SScan    = 4'd3;
  localparam logic [3:0] SScanEnd = 4'd4;
  localparam logic [3:0] SPick    = 4'd5;
  localparam logic [3:0] SUpd     = 4'd6;
  localparam logic [3:0] SCOrd    = 4'd7;
  localparam logic [3:0] SCRd     = 4'd8;
  localparam logic [3:0] SChk     = 4'd9;
  localparam logic [3:0] SChkEnd  = 4'd10;
  localparam logic [3:0] SEmit    = 4'd11;

  logic [3:0] state_q, state_d;
  logic go;
  assign go = start_i && (state_q == SIdle);
  assign busy_o = (state_q != SIdle);

  // reset enters the clear sweep so the store starts empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SClr;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: begin
        cmd_o.rst_i = 1'b1;
        cmd_o.rst_j = 1'b1;
        if (go) begin
          unique case (mode_i)
            mcs_pkg::ModeAdd:   cmd_o.add = 1'b1;
            mcs_pkg::ModeClear: state_d = SClr;
            mcs_pkg::ModeRun:   state_d = SInit;
            default: ;
          endcase
        end
      end
      SClr: begin
        cmd_o.clr_row = 1'b1;
        cmd_o.inc_i = 1'b1;
        if (sweep_i) state_d = SIdle;
      end
      SInit: begin
        cmd_o.init = 1'b1;
        cmd_o.inc_i = 1'b1;
        if (sweep_i) begin
          cmd_o.inc_i = 1'b0;
          cmd_o.rst_i = 1'b1;
          state_d = sts_i.empty ? SIdle : SScan;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        cmd_o.inc_j = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.inc_j = 1'b0;
          cmd_o.rst_j = 1'b1;
          state_d = SScanEnd;
        end
      end
      // last scan read is compared here
      SScanEnd: state_d = SPick;
      SPick: begin
        cmd_o.pick = 1'b1;
        state_d = SUpd;
      end
      SUpd: begin
        cmd_o.upd = 1'b1;
        cmd_o.inc_j = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.inc_j = 1'b0;
          cmd_o.rst_j = 1'b1;
          if (sts_i.i_last) begin
            cmd_o.rst_i = 1'b1;
            state_d = SCOrd;
          end else begin
            cmd_o.inc_i = 1'b1;
            state_d = SScan;
          end
        end
      end
      SCOrd: begin
        cmd_o.col_ord = 1'b1;
        state_d = SCRd;
      end
      SCRd: begin
        cmd_o.col_rd = 1'b1;
        state_d = SChk;
      end
      SChk: begin
        cmd_o.col_chk = 1'b1;
        cmd_o.inc_j = 1'b1;
        if (sts_i.j_last) begin
          cmd_o.inc_j = 1'b0;
          cmd_o.rst_j = 1'b1;
          state_d = SChkEnd;
        end
      end
      // last neighbor color is folded in here
      SChkEnd: state_d = SEmit;
      SEmit: begin
        cmd_o.col_emit = 1'b1;
        if (sts_i.i_last) state_d = SIdle;
        else begin
          cmd_o.inc_i = 1'b1;
          state_d = SCOrd;
        end
      end
      default: state_d = SIdle;
    endcase
  end
endmodule
`default_nettype wire

/* sv/mcs_greedy_graph_coloring.sv */
`default_nettype none
// Maximum cardinality search with greedy coloring.
// Requests enter on start_i (mode_i, from_node_i, to_node_i) at an edge where
// busy_o is low. An add request completes in its accept cycle; busy_o stays low.
// A clear request holds busy_o high while it clears every row, one row a cycle.
// A run request over N active nodes holds busy_o high while it resets the node
// tables over all MAX_NODES entries, then runs N search rounds (N-entry scan,
// compare drain, pick, N weight updates), then colors each node in search order
// (order read, row read, N neighbor checks, drain, emit).
// The scans go over the registered node tables one entry a cycle.
// Each result (node_index_o, node_color_o, last_o) is shown for one cycle with
// result_valid_o high; the receiver cannot stall, so none is held back.
// last_o marks the final node; N = 0 gives no results.
// node_count is written over the APB port at address 0, reset value 64; write
// it only while busy_o is low.
// Reset starts a clear sweep over all MAX_NODES rows with busy_o high, so the
// adjacency store is empty before the first request is taken.
module mcs_greedy_graph_coloring #(
  parameter int MAX_NODES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [5:0]  from_node_i,
  input  wire logic [5:0]  to_node_i,
  output logic             result_valid_o,
  output logic [5:0]       node_index_o,
  output logic [5:0]       node_color_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [6:0] node_count_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) node_count_q <= mcs_pkg::NodeCountReset;
    else if (psel && penable && pwrite && paddr == mcs_pkg::AddrNodeCount)
      node_count_q <= pwdata[6:0];
  end
  assign prdata = (paddr == mcs_pkg::AddrNodeCount) ? {25'd0, node_count_q} : 32'd0;

  mcs_pkg::mcs_cmd_t cmd;
  mcs_pkg::mcs_sts_t sts;

  // sweep counter end for clear/init passes over all stored rows
  logic [IW-1:0] sw_q;
  logic sweep_last;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sw_q <= '0;
    else if (cmd.clr_row || cmd.init) sw_q <= sw_q + IW'(1);
    else sw_q <= '0;
  end
  assign sweep_last = (32'(sw_q) == MAX_NODES - 1);

  logic busy_c;
  mcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .mode_i, .sweep_i(sweep_last),
    .busy_o(busy_c), .cmd_o(cmd), .sts_i(sts)
  );
  assign busy_o = busy_c;

  mcs_datapath #(.MaxNodes(MAX_NODES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .node_count_i(node_count_q), .from_node_i, .to_node_i,
    .res_valid_o(result_valid_o), .node_index_o, .node_color_o, .last_o
  );
endmodule
`default_nettype wire

/* sv/mcs_checker.sv */
`default_nettype none
module mcs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic result_valid_o,
  input wire logic last_o
);
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o) else $error("result after last");
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> !result_valid_o) else $error("results back to back");
endmodule
bind mcs_greedy_graph_coloring mcs_checker u_chk (.*);
`default_nettype wire

/* sim/tb_mcs_greedy_graph_coloring.sv */
`timescale 1ns / 1ps
module tb_mcs_greedy_graph_coloring;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  mode_i = '0;
  logic [5:0]  from_node_i = '0;
  logic [5:0]  to_node_i = '0;
  logic        result_valid_o;
  logic [5:0]  node_index_o;
  logic [5:0]  node_color_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [5:0] node;
    logic [5:0] color;
    logic       last;
  } coloring_t;

  mcs_greedy_graph_coloring DUT (.*);

  // shadow state of the block
  logic [63:0] adj_rows [64];
  logic [6:0]  active_count;
  coloring_t   coloring_q [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          idle_on = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_mcs_greedy_graph_coloring: FAIL");
      $finish;
    end
  end

  // search order and greedy colors for one run request
  function automatic void predict_coloring();
    int n;
    int best;
    int pick;
    int c;
    logic [6:0]  weight [64];
    logic        removed [64];
    logic [6:0]  color [64];
    int          order [64];
    logic [63:0] act;
    logic [63:0] nb;
    logic [63:0] used;
    coloring_t   res;
    n = (active_count > 7'd64) ? 64 : int'(active_count);
    act = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (int k = 0; k < 64; k++) begin
      weight[k] = '0;
      removed[k] = 1'b0;
      color[k] = 7'd127;
    end
    for (int i = 0; i < n; i++) begin
      best = -1;
      pick = 0;
      for (int j = 0; j < n; j++) begin
        if (!removed[j] && int'(weight[j]) > best) begin
          best = int'(weight[j]);
          pick = j;
        end
      end
      order[i] = pick;
      removed[pick] = 1'b1;
      nb = adj_rows[pick] & act;
      for (int j = 0; j < n; j++)
        if (nb[j]) weight[j] = weight[j] + 7'd1;
    end
    for (int i = 0; i < n; i++) begin
      nb = adj_rows[order[i]] & act;
      used = '0;
      for (int j = 0; j < n; j++)
        if (nb[j] && color[j] != 7'd127) used[color[j][5:0]] = 1'b1;
      c = 0;
      while (c < 63 && used[c]) c++;
      color[order[i]] = 7'(c);
      res.node = 6'(order[i]);
      res.color = 6'(c);
      res.last = (i + 1 == n);
      coloring_q.insert(coloring_q.size(), res);
    end
  endfunction

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    coloring_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (coloring_q.size() == 0) begin
        $display("%0t: unexpected result node=%0d color=%0d last=%0d", $time,
                 node_index_o, node_color_o, last_o);
        fail_cnt++;
      end else begin
        exp_res = coloring_q.pop_front();
        if (node_index_o !== exp_res.node) begin
          $display("%0t: node_index expected %0d actual %0d", $time, exp_res.node,
                   node_index_o);
          fail_cnt++;
        end
        if (node_color_o !== exp_res.color) begin
          $display("%0t: node_color expected %0d actual %0d", $time, exp_res.color,
                   node_color_o);
          fail_cnt++;
        end
        if (last_o !== exp_res.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_res.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  // one request, with an optional random gap before it; start stays high
  // after acceptance until the next gap or drain lowers it
  task automatic send_request(input logic [1:0] mode, input logic [5:0] from,
                              input logic [5:0] to);
    while (idle_on && $urandom_range(99) < 12) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= mode;
    from_node_i <= from;
    to_node_i <= to;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (mode)
      mcs_pkg::ModeAdd:   adj_rows[from][to] = 1'b1;
      mcs_pkg::ModeClear: for (int k = 0; k < 64; k++) adj_rows[k] = '0;
      mcs_pkg::ModeRun:   predict_coloring();
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (coloring_q.size() != 0) @(posedge clk_i);
    // clear sweeps and add requests produce no results
    while (busy_o) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [6:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= mcs_pkg::AddrNodeCount;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_count = value;
  endtask

  task automatic add_random_edges(input int cnt, input int span);
    logic [5:0] a;
    logic [5:0] b;
    for (int k = 0; k < cnt; k++) begin
      a = 6'($urandom_range(span - 1));
      b = 6'($urandom_range(span - 1));
      send_request(mcs_pkg::ModeAdd, a, b);
      if ($urandom_range(1)) send_request(mcs_pkg::ModeAdd, b, a);
    end
  endtask

  task automatic test_directed();
    // empty graph over all 64 nodes at reset count
    send_request(mcs_pkg::ModeRun, '0, '0);
    // extremes, self loop, duplicate and ignored mode
    send_request(mcs_pkg::ModeAdd, 6'd0, 6'd63);
    send_request(mcs_pkg::ModeAdd, 6'd63, 6'd0);
    send_request(mcs_pkg::ModeAdd, 6'd63, 6'd0);
    send_request(mcs_pkg::ModeAdd, 6'd5, 6'd5);
    send_request(mcs_pkg::ModeAdd, 6'd21, 6'd42);
    send_request(mcs_pkg::ModeAdd, 6'd42, 6'd21);
    send_request(ModeIgnored, 6'd63, 6'd63);
    send_request(mcs_pkg::ModeRun, '0, '0);
    // triangle plus one entry outside the active nodes
    write_node_count(7'd4);
    send_request(mcs_pkg::ModeAdd, 6'd0, 6'd1);
    send_request(mcs_pkg::ModeAdd, 6'd1, 6'd2);
    send_request(mcs_pkg::ModeAdd, 6'd2, 6'd0);
    send_request(mcs_pkg::ModeAdd, 6'd1, 6'd0);
    send_request(mcs_pkg::ModeAdd, 6'd3, 6'd50);
    send_request(mcs_pkg::ModeRun, '0, '0);
    write_node_count(7'd1);
    send_request(mcs_pkg::ModeRun, '0, '0);
    write_node_count(7'd0);
    send_request(mcs_pkg::ModeRun, '0, '0);
    write_node_count(7'd127);
    send_request(mcs_pkg::ModeRun, '0, '0);
    send_request(mcs_pkg::ModeClear, '0, '0);
    send_request(mcs_pkg::ModeRun, '0, '0);
  endtask

  task automatic test_random_small();
    int n;
    for (int r = 0; r < 7; r++) begin
      n = $urandom_range(2, 12);
      write_node_count(7'(n));
      send_request(mcs_pkg::ModeClear, '0, '0);
      add_random_edges($urandom_range(2, 10), n + 2);
      if ($urandom_range(3) == 0) send_request(ModeIgnored, 6'($urandom), 6'($urandom));
      send_request(mcs_pkg::ModeRun, '0, '0);
    end
  endtask

  task automatic test_random_full();
    idle_on = 1'b0;
    write_node_count(7'd64);
    send_request(mcs_pkg::ModeClear, '0, '0);
    add_random_edges(12, 64);
    send_request(mcs_pkg::ModeRun, '0, '0);
    idle_on = 1'b1;
    add_random_edges(6, 64);
    send_request(mcs_pkg::ModeRun, '0, '0);
  endtask

  initial begin
    for (int k = 0; k < 64; k++) adj_rows[k] = '0;
    active_count = mcs_pkg::NodeCountReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_small();
    test_random_full();
    wait_drained();
    if (fail_cnt == 0) begin
      $display("tb_mcs_greedy_graph_coloring: PASS");
    end else begin
      $display("tb_mcs_greedy_graph_coloring: FAIL");
    end
    $finish;
  end
endmodule
